// ----- sv/fte_pkg.sv -----
// Shared types and constants for the Fortran tab expander.
// Holds the item structs, the queue command and a small helper function.
`timescale 1ns / 1ps

package fte_pkg;

    localparam int FTE_MAX_TAB = 32;
    localparam int CNT_W       = 6;
    localparam int Q_DEPTH     = 2;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] COL_SIX  = 3'd6;
    localparam logic [2:0] PRE_CONT = 3'd5;
    localparam logic [2:0] PRE_TAB  = 3'd6;
    localparam logic [6:0] TAB_DFLT = 7'd4;

    typedef enum logic [0:0] {
        CFG_TAB_SIZE   = 1'b0,
        CFG_FIXED_FORM = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BODY_NONE,
        BODY_CHAR,
        BODY_SPACE
    } t_body;

    typedef struct packed {
        logic [7:0] char_in;
        logic       text_end_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_out;
        logic       run_last;
        logic       text_end_out;
    } t_out_item;

    typedef struct packed {
        logic [2:0]       pre;
        t_body            kind;
        logic [CNT_W-1:0] nsp;
        logic [7:0]       ch;
        logic             text_end;
    } t_cmd;

    function automatic logic [2:0] six_mod(input logic [6:0] t);
        logic [2:0] r;
        begin
            unique case (t)
                7'd1, 7'd2, 7'd3, 7'd6: r = 3'd0;
                7'd4:                   r = 3'd2;
                7'd5:                   r = 3'd1;
                default:                r = 3'd6;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- sv/fte_queue.sv -----
// Short command queue between the front and back parts.
// Depends on fte_pkg for the queue depth.
`timescale 1ns / 1ps

module fte_queue
    import fte_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    logic [W-1:0]  r_mem [Q_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
        begin
            return (p == AW'(Q_DEPTH - 1)) ? '0 : p + AW'(1);
        end
    endfunction

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= adv(r_wr);
            end
            if (i_pop) begin
                r_rd <= adv(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ----- sv/fte_front.sv -----
// Front part: takes input items, tracks line columns and turns each item
// into at most one expansion command. Holds the configuration registers.
// Depends on fte_pkg.
`timescale 1ns / 1ps

module fte_front
    import fte_pkg::*;
#(
    parameter int MAX_TAB = FTE_MAX_TAB
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [5:0] i_cfg_data,
    input  logic       i_in_valid,
    input  t_in_item   i_in_item,
    output logic       o_in_stall,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_cmd       o_q_cmd
);

    localparam int TW = $clog2(MAX_TAB + 1);

    logic [5:0]    r_tab;
    logic          r_fixed;
    logic          r_ls, r_pend;
    logic [2:0]    r_col;
    logic [TW-1:0] r_phase, r_red;
    logic          r_busy;

    logic          n_ls, n_pend;
    logic [2:0]    n_col;
    logic [TW-1:0] n_phase;

    logic [6:0]    w_t0;
    logic [TW-1:0] w_t, w_six;
    logic          w_acc, w_digit, w_tab, w_nl, w_hb;
    logic [2:0]    w_col_in;
    logic [TW-1:0] w_ph_in;
    logic [TW:0]   w_ph_inc;
    logic [CNT_W:0] w_col_sum;
    t_cmd          w_cmd;

    assign w_t0  = (r_tab == 6'd0) ? TAB_DFLT : {1'b0, r_tab};
    assign w_t   = (w_t0 > 7'(MAX_TAB)) ? TW'(MAX_TAB) : TW'(w_t0);
    assign w_six = TW'(six_mod(7'(w_t)));

    assign o_in_stall = r_busy | i_q_full;
    assign w_acc      = i_in_valid && !o_in_stall;

    assign w_digit = (i_in_item.char_in >= CH_ONE) && (i_in_item.char_in <= CH_NINE);
    assign w_tab   = (i_in_item.char_in == CH_TAB);
    assign w_nl    = (i_in_item.char_in == CH_NL);

    assign w_col_in = r_pend ? COL_SIX : r_col;
    assign w_ph_in  = r_pend ? w_six : r_red;
    assign w_ph_inc = {1'b0, w_ph_in} + (TW+1)'(1);

    always_comb begin
        n_ls      = r_ls;
        n_pend    = r_pend;
        n_col     = r_col;
        n_phase   = r_red;
        w_hb      = 1'b0;
        w_col_sum = '0;
        w_cmd          = '0;
        w_cmd.kind     = BODY_NONE;
        w_cmd.ch       = i_in_item.char_in;
        w_cmd.text_end = i_in_item.text_end_in;

        if (r_pend) begin
            n_pend    = 1'b0;
            n_ls      = 1'b0;
            n_col     = COL_SIX;
            n_phase   = w_six;
            if (w_digit) begin
                w_cmd.pre  = PRE_CONT;
                w_cmd.kind = BODY_CHAR;
            end else begin
                w_cmd.pre = PRE_TAB;
                w_hb      = 1'b1;
            end
        end else if (r_ls && r_fixed && w_tab) begin
            n_ls = 1'b0;
            if (i_in_item.text_end_in) begin
                w_cmd.pre = PRE_TAB;
            end else begin
                n_pend = 1'b1;
            end
        end else begin
            w_hb = 1'b1;
        end

        if (w_hb) begin
            n_ls = 1'b0;
            if (w_tab) begin
                w_cmd.kind = BODY_SPACE;
                if (r_fixed && (w_col_in < COL_SIX)) begin
                    w_cmd.nsp = CNT_W'(COL_SIX - w_col_in);
                    n_col     = COL_SIX;
                    n_phase   = w_six;
                end else begin
                    w_cmd.nsp = CNT_W'(w_t - w_ph_in);
                    w_col_sum = (CNT_W+1)'(w_col_in) + (CNT_W+1)'(w_cmd.nsp);
                    n_col     = (w_col_sum > (CNT_W+1)'(COL_SIX)) ? COL_SIX
                                                                  : 3'(w_col_sum);
                    n_phase   = '0;
                end
            end else begin
                w_cmd.kind = BODY_CHAR;
                if (w_nl) begin
                    n_ls    = 1'b1;
                    n_col   = '0;
                    n_phase = '0;
                end else begin
                    n_col   = (w_col_in >= COL_SIX) ? COL_SIX : w_col_in + 3'd1;
                    n_phase = (w_ph_inc == (TW+1)'(w_t)) ? '0 : TW'(w_ph_inc);
                end
            end
        end

        if (i_in_item.text_end_in) begin
            n_pend  = 1'b0;
            n_ls    = 1'b1;
            n_col   = '0;
            n_phase = '0;
        end
    end

    assign o_q_push = w_acc && ((w_cmd.kind != BODY_NONE) || (w_cmd.pre != 3'd0));
    assign o_q_cmd  = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab   <= 6'(TAB_DFLT);
            r_fixed <= 1'b1;
            r_ls    <= 1'b1;
            r_pend  <= 1'b0;
            r_col   <= '0;
            r_phase <= '0;
            r_red   <= '0;
            r_busy  <= 1'b0;
        end else begin
            if (r_busy) begin
                if (r_red >= w_t) begin
                    r_red <= r_red - w_t;
                end else begin
                    r_busy <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_TAB_SIZE: begin
                        r_tab  <= i_cfg_data;
                        r_red  <= r_phase;
                        r_busy <= 1'b1;
                    end
                    CFG_FIXED_FORM: begin
                        r_fixed <= i_cfg_data[0];
                    end
                endcase
            end
            if (w_acc) begin
                r_ls    <= n_ls;
                r_pend  <= n_pend;
                r_col   <= n_col;
                r_phase <= n_phase;
                r_red   <= n_phase;
            end
        end
    end

endmodule

// ----- sv/fte_back.sv -----
// Back part: expands queued commands into output items, one per cycle while
// the output is not stalled, through a registered output stage. Depends on fte_pkg.
`timescale 1ns / 1ps

module fte_back
    import fte_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_cmd      i_q_cmd,
    output logic      o_q_pop,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    logic             r_act;
    logic [2:0]       r_pre;
    t_body            r_kind;
    logic [CNT_W-1:0] r_nsp;
    logic [7:0]       r_ch;
    logic             r_end;
    logic             r_oval;
    t_out_item        r_oitem;

    logic      w_free, w_emit, w_last, w_load;
    t_out_item w_item;

    assign w_free = !r_oval || !i_out_stall;
    assign w_emit = r_act && w_free;

    always_comb begin
        w_item          = '0;
        w_item.char_out = CH_SPACE;
        w_last          = 1'b0;
        if (r_pre != 3'd0) begin
            w_last = (r_pre == 3'd1) && (r_kind == BODY_NONE);
        end else if (r_kind == BODY_SPACE) begin
            w_last = (r_nsp == CNT_W'(1));
        end else begin
            w_item.char_out = r_ch;
            w_last          = 1'b1;
        end
        w_item.run_last     = w_last;
        w_item.text_end_out = w_last && r_end;
    end

    assign w_load  = (!r_act || (w_emit && w_last)) && i_q_valid;
    assign o_q_pop = w_load;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pre  <= i_q_cmd.pre;
            r_kind <= i_q_cmd.kind;
            r_nsp  <= i_q_cmd.nsp;
            r_ch   <= i_q_cmd.ch;
            r_end  <= i_q_cmd.text_end;
        end else if (w_emit) begin
            if (r_pre != 3'd0) begin
                r_pre <= r_pre - 3'd1;
            end else if (r_kind == BODY_SPACE) begin
                r_nsp <= r_nsp - CNT_W'(1);
            end
        end
        if (w_emit) begin
            r_oitem <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_oval <= 1'b0;
        end else begin
            if (!r_act || (w_emit && w_last)) begin
                r_act <= i_q_valid;
            end
            if (w_free) begin
                r_oval <= w_emit;
            end
        end
    end

    assign o_out_valid = r_oval;
    assign o_out_item  = r_oitem;

endmodule

// ----- sv/fortran_tab_expander.sv -----
// Fortran tab expander top level: front, command queue and back part.
// Throughput: one output item per cycle while i_out_stall is low.
// A tab_size write stalls input while the phase reduces.
// Reset (synchronous, active low): tab_size 4, fixed form, line start, empty queue.
`timescale 1ns / 1ps

module fortran_tab_expander
    import fte_pkg::*;
#(
    parameter int MAX_TAB = FTE_MAX_TAB
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic [5:0] i_cfg_data,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    logic w_push, w_full, w_pop, w_qvalid;
    t_cmd w_cmd_in, w_cmd_out;

    fte_front #(
        .MAX_TAB (MAX_TAB)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_q_full   (w_full),
        .o_q_push   (w_push),
        .o_q_cmd    (w_cmd_in)
    );

    fte_queue #(
        .W ($bits(t_cmd))
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_data  (w_cmd_out)
    );

    fte_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_qvalid),
        .i_q_cmd     (w_cmd_out),
        .o_q_pop     (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule
